@@ hdl/xbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbr_pkg: shared types and constants
// Operation codes, the request record passed from the front part to the back
// part, and the back-end state machine type.
// ----------------------------------------------------------------------------
package xbr_pkg;

  typedef enum logic [1:0] {
    OP_U32 = 2'd0,
    OP_S32 = 2'd1,
    OP_U64 = 2'd2,
    OP_S64 = 2'd3
  } op_t;

  localparam logic [63:0] ODD_GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;
  localparam int unsigned ROT_FINAL  = 45;
  localparam int unsigned SHIFT_T    = 17;

  // Classified request: empty requests carry their answer in range_min.
  typedef struct packed {
    logic        empty;
    logic        wide;
    logic [63:0] range_min;
    logic [63:0] span;
  } req_t;

  typedef enum logic [3:0] {
    ST_SEED,
    ST_IDLE,
    ST_THR,
    ST_DRAW,
    ST_MUL1,
    ST_MUL2,
    ST_CHECK,
    ST_MOD,
    ST_DONE
  } st_t;

endpackage

@@ hdl/xbr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbr_req_if / xbr_rsp_if: request and result channels
// Valid/ready channels carrying the request fields and the drawn value.
// ----------------------------------------------------------------------------
interface xbr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] range_min;
  logic [63:0] range_max;
  modport source (output valid, operation, range_min, range_max, input ready);
  modport sink (input valid, operation, range_min, range_max, output ready);
endinterface

interface xbr_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

@@ hdl/xbr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbr_front: request classifier and queue
// Accepts transactions, decides empty ranges, forms the span at the width in
// use and holds up to two classified requests for the back part.
// ----------------------------------------------------------------------------
module xbr_front (
  input  logic          clk,
  input  logic          rst_n,
  xbr_req_if.sink       in_ch,
  output xbr_pkg::req_t q_data,
  output logic          q_valid,
  input  logic          q_pop
);

  xbr_pkg::req_t cls;
  xbr_pkg::req_t mem_r [2];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  logic          wide, sgn, lt;

  // Classify the incoming request.
  always_comb begin
    wide = in_ch.operation[1];
    sgn  = in_ch.operation[0];
    if (wide) begin
      lt = sgn ? ($signed(in_ch.range_min) < $signed(in_ch.range_max))
               : (in_ch.range_min < in_ch.range_max);
      cls.range_min = in_ch.range_min;
      cls.span      = in_ch.range_max - in_ch.range_min;
    end else begin
      lt = sgn ? ($signed(in_ch.range_min[31:0]) < $signed(in_ch.range_max[31:0]))
               : (in_ch.range_min[31:0] < in_ch.range_max[31:0]);
      cls.range_min = {32'd0, in_ch.range_min[31:0]};
      cls.span      = {32'd0, in_ch.range_max[31:0] - in_ch.range_min[31:0]};
    end
    cls.empty = !lt;
    cls.wide  = wide;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_data      = mem_r[rp_r];

  // Queue pointers.
  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = q_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !push) else $error("push into full queue");

endmodule

@@ hdl/xbr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbr_back: generator and bounded draw engine
// Holds the xoshiro256** state, reseeds it by four SplitMix64 steps, and for
// each request computes the rejection threshold and the draw remainder with a
// bit-serial divider.
// ----------------------------------------------------------------------------
module xbr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [63:0]   cfg_wr_data,
  input  xbr_pkg::req_t q_data,
  input  logic          q_valid,
  output logic          q_pop,
  xbr_rsp_if.source     out_ch
);

  xbr_pkg::st_t st_r, st_nxt;
  logic [63:0]  w0_r, w1_r, w2_r, w3_r;
  logic [63:0]  sm_r;        // SplitMix64 running sum
  logic [63:0]  z_r;         // mixer pipeline value
  logic [63:0]  mop_r;       // mixer multiplier operand
  logic [63:0]  macc_r;      // mixer partial product
  logic [1:0]   sidx_r;      // which word is being seeded
  logic [2:0]   sph_r;       // seed step phase
  logic [63:0]  thr_r, draw_r, rem_r, quo_r, res_r;
  logic [6:0]   bit_r;
  xbr_pkg::req_t cur_r;
  logic         out_v_r;

  logic [65:0]  trial;
  logic [63:0]  divsor, raw, zm, kmul, mlo, w3x;
  logic [31:0]  mxa, mxb, mx;

  assign divsor = cur_r.span;
  assign out_ch.valid = out_v_r;
  assign out_ch.value = res_r;

  // Next-state logic; a seed write always restarts the seeding sequence.
  always_comb begin
    st_nxt = st_r;
    if (cfg_wr_en) begin
      st_nxt = xbr_pkg::ST_SEED;
    end else begin
      case (st_r)
        xbr_pkg::ST_SEED:  if (sidx_r == 2'd3 && sph_r == 3'd7) st_nxt = xbr_pkg::ST_IDLE;
        xbr_pkg::ST_IDLE: begin
          if (q_valid && !out_v_r) st_nxt = q_data.empty ? xbr_pkg::ST_DONE
                                                         : xbr_pkg::ST_THR;
        end
        xbr_pkg::ST_THR:   if (bit_r == 7'd0) st_nxt = xbr_pkg::ST_DRAW;
        xbr_pkg::ST_DRAW:  st_nxt = xbr_pkg::ST_MUL1;
        xbr_pkg::ST_MUL1:  st_nxt = xbr_pkg::ST_MUL2;
        xbr_pkg::ST_MUL2:  st_nxt = xbr_pkg::ST_CHECK;
        xbr_pkg::ST_CHECK: st_nxt = (draw_r < thr_r) ? xbr_pkg::ST_DRAW : xbr_pkg::ST_MOD;
        xbr_pkg::ST_MOD:   if (bit_r == 7'd0) st_nxt = xbr_pkg::ST_DONE;
        xbr_pkg::ST_DONE:  st_nxt = xbr_pkg::ST_IDLE;
        default:           st_nxt = xbr_pkg::ST_IDLE;
      endcase
    end
  end

  // Output decode.
  always_comb begin
    q_pop = (st_r == xbr_pkg::ST_IDLE) && !cfg_wr_en && q_valid && !out_v_r;
  end

  // Division step, scrambler multiply by five and the split mixer multiply.
  always_comb begin
    trial = {1'b0, rem_r, quo_r[63]} - {2'b00, divsor};
    raw   = {w1_r[61:0], 2'b0} + w1_r;           // * 5
    zm    = z_r ^ (sph_r == 3'd1 ? (z_r >> 30) : (z_r >> 27));
    kmul  = sph_r[2] ? xbr_pkg::MIX_MUL_B : xbr_pkg::MIX_MUL_A;
    mlo   = {32'd0, zm[31:0]} * {32'd0, kmul[31:0]};
    mxa   = (sph_r inside {3'd2, 3'd5}) ? mop_r[31:0] : mop_r[63:32];
    mxb   = (sph_r inside {3'd2, 3'd5}) ? kmul[63:32] : kmul[31:0];
    mx    = mxa * mxb;
    w3x   = w3_r ^ w1_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= xbr_pkg::ST_SEED;
      sm_r    <= 64'd0;
      sidx_r  <= 2'd0;
      sph_r   <= 3'd0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == xbr_pkg::ST_DONE) begin
        out_v_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        sm_r   <= cfg_wr_data;
        sidx_r <= 2'd0;
        sph_r  <= 3'd0;
      end else if (st_r == xbr_pkg::ST_SEED) begin
        sph_r <= sph_r + 3'd1;
        if (sph_r == 3'd0) sm_r <= sm_r + xbr_pkg::ODD_GOLDEN;
        if (sph_r == 3'd7) sidx_r <= sidx_r + 2'd1;
      end
    end
  end

  // Datapath without reset.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
      quo_r <= q_data.wide ? (64'd0 - q_data.span)
                           : {32'd0 - q_data.span[31:0], 32'd0};
      bit_r <= q_data.wide ? 7'd64 : 7'd32;
      rem_r <= 64'd0;
      if (q_data.empty) begin
        res_r <= q_data.range_min;
      end
    end
    case (st_r)
      xbr_pkg::ST_SEED: begin
        // Phase 0 adds, phases 1-3 and 4-6 multiply in 32-bit pieces, 7 stores.
        case (sph_r)
          3'd0: z_r <= sm_r + xbr_pkg::ODD_GOLDEN;
          3'd1, 3'd4: begin
            mop_r  <= zm;
            macc_r <= mlo;
          end
          3'd2, 3'd5: macc_r <= macc_r + {mx, 32'd0};
          3'd3, 3'd6: z_r <= macc_r + {mx, 32'd0};
          default: begin
            case (sidx_r)
              2'd0: w0_r <= z_r ^ (z_r >> 31);
              2'd1: w1_r <= z_r ^ (z_r >> 31);
              2'd2: w2_r <= z_r ^ (z_r >> 31);
              default: w3_r <= z_r ^ (z_r >> 31);
            endcase
          end
        endcase
      end
      xbr_pkg::ST_THR, xbr_pkg::ST_MOD: begin
        if (bit_r != 7'd0) begin
          quo_r <= {quo_r[62:0], 1'b0};
          rem_r <= trial[65] ? {rem_r[62:0], quo_r[63]} : trial[63:0];
          bit_r <= bit_r - 7'd1;
        end else if (st_r == xbr_pkg::ST_THR) begin
          thr_r <= rem_r;
        end else if (cur_r.wide) begin
          res_r <= cur_r.range_min + rem_r;
        end else begin
          res_r <= {32'd0, cur_r.range_min[31:0] + rem_r[31:0]};
        end
      end
      xbr_pkg::ST_DRAW: begin
        // Scrambler first stage and state update.
        z_r  <= {raw[56:0], raw[63:57]};
        w2_r <= w2_r ^ w0_r ^ (w1_r << xbr_pkg::SHIFT_T);
        w3_r <= {w3x[63-xbr_pkg::ROT_FINAL:0], w3x[63:64-xbr_pkg::ROT_FINAL]};
        w1_r <= w1_r ^ w2_r ^ w0_r;
        w0_r <= w0_r ^ w3_r ^ w1_r;
      end
      xbr_pkg::ST_MUL1: z_r <= {z_r[60:0], 3'b0} + z_r;  // * 9
      xbr_pkg::ST_MUL2: draw_r <= cur_r.wide ? z_r : {32'd0, z_r[63:32]};
      xbr_pkg::ST_CHECK: begin
        quo_r <= cur_r.wide ? draw_r : {draw_r[31:0], 32'd0};
        bit_r <= cur_r.wide ? 7'd64 : 7'd32;
        rem_r <= 64'd0;
      end
      default: ;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> out_v_r) else $error("result dropped");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == xbr_pkg::ST_IDLE)) else $error("pop while busy");
  a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == xbr_pkg::ST_CHECK) |-> (thr_r < cur_r.span)) else $error("threshold too large");

endmodule

@@ hdl/xoshiro_bounded_random_top.sv @@
`timescale 1ns / 1ps
// An empty range is answered without a draw; otherwise the result waits on
// the one-bit-a-cycle divider that forms the rejection threshold and then the
// final remainder, and each rejected draw adds another draw and check.
// Throughput: one transaction at a time in the back part; a two-entry queue
// in front. Reset (synchronous, rst_n low) loads the state from seed zero by
// the seeding sequence; a seed write reloads it in the same way after the write.
// ----------------------------------------------------------------------------
// xoshiro_bounded_random_top: bounded uniform random generator
// Connects the request classifier to the generator and draw engine.
// ----------------------------------------------------------------------------
module xoshiro_bounded_random_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  xbr_req_if.sink     in_ch,
  xbr_rsp_if.source   out_ch
);

  xbr_pkg::req_t q_data;
  logic          q_valid, q_pop;

  xbr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  xbr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_data      (q_data),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the bounded uniform random generator
// A queue-fed driver sends requests. A monitor compares each drawn value with
// a local xoshiro256** model that has SplitMix64 seeding. Several seeds are
// used, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 100;

  typedef struct {
    xbr_pkg::op_t operation;
    logic [63:0]  range_min;
    logic [63:0]  range_max;
  } request_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [63:0] cfg_wr_data;

  xbr_req_if req_ch ();
  xbr_rsp_if rsp_ch ();

  xoshiro_bounded_random_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (req_ch),
    .out_ch      (rsp_ch)
  );

  request_t    pending_reqs[$];
  logic [63:0] expected_values[$];
  logic [63:0] gen_state[4];
  int unsigned fail_count;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned idle_cycles;

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reload the model state through four SplitMix64 steps.
  function automatic void load_seed(input logic [63:0] s);
    logic [63:0] z;
    for (int i = 0; i < 4; i++) begin
      s = s + xbr_pkg::ODD_GOLDEN;
      z = s;
      z = (z ^ (z >> 30)) * xbr_pkg::MIX_MUL_A;
      z = (z ^ (z >> 27)) * xbr_pkg::MIX_MUL_B;
      gen_state[i] = z ^ (z >> 31);
    end
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned k);
    return (v << k) | (v >> (64 - k));
  endfunction

  // One xoshiro256** step: returns the output and advances the state.
  function automatic logic [63:0] next_draw();
    logic [63:0] result;
    logic [63:0] t;
    result = rotl(gen_state[1] * 64'd5, 7) * 64'd9;
    t = gen_state[1] << xbr_pkg::SHIFT_T;
    gen_state[2] ^= gen_state[0];
    gen_state[3] ^= gen_state[1];
    gen_state[1] ^= gen_state[2];
    gen_state[0] ^= gen_state[3];
    gen_state[2] ^= t;
    gen_state[3] = rotl(gen_state[3], xbr_pkg::ROT_FINAL);
    return result;
  endfunction

  // Expected value of one request, with rejection of biased draws.
  function automatic logic [63:0] bounded_value(input request_t r);
    logic [31:0] lo32, hi32, span32, thr32, d32;
    logic [63:0] span64, thr64, d64;
    logic        empty;
    if (r.operation == xbr_pkg::OP_U32 || r.operation == xbr_pkg::OP_S32) begin
      lo32 = r.range_min[31:0];
      hi32 = r.range_max[31:0];
      empty = (r.operation == xbr_pkg::OP_S32) ? !($signed(lo32) < $signed(hi32))
                                               : !(lo32 < hi32);
      if (empty) return {32'd0, lo32};
      span32 = hi32 - lo32;
      thr32 = (32'd0 - span32) % span32;
      do begin
        d64 = next_draw();
        d32 = d64[63:32];
      end while (d32 < thr32);
      return {32'd0, lo32 + d32 % span32};
    end
    empty = (r.operation == xbr_pkg::OP_S64) ? !($signed(r.range_min) < $signed(r.range_max))
                                             : !(r.range_min < r.range_max);
    if (empty) return r.range_min;
    span64 = r.range_max - r.range_min;
    thr64 = (64'd0 - span64) % span64;
    do begin
      d64 = next_draw();
    end while (d64 < thr64);
    return r.range_min + d64 % span64;
  endfunction

  // Gap draw: at least a quarter of the items run back to back.
  function automatic int unsigned draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Driver: presents queued requests and models each accepted transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid     <= 1'b0;
      req_ch.operation <= xbr_pkg::OP_U32;
      req_ch.range_min <= '0;
      req_ch.range_max <= '0;
      send_gap         <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_values.push_back(bounded_value('{xbr_pkg::op_t'(req_ch.operation),
                                                  req_ch.range_min, req_ch.range_max}));
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          request_t r;
          r = pending_reqs.pop_front();
          req_ch.operation <= r.operation;
          req_ch.range_min <= r.range_min;
          req_ch.range_max <= r.range_max;
          req_ch.valid     <= 1'b1;
          send_gap         <= draw_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result channel and checks each result transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      recv_stall   <= 0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      int unsigned s;
      if (expected_values.size() == 0) begin
        $error("unexpected result transaction: value actual %h", rsp_ch.value);
        fail_count++;
      end else begin
        logic [63:0] exp_value;
        exp_value = expected_values.pop_front();
        if (rsp_ch.value !== exp_value) begin
          $error("value mismatch: expected %h actual %h", exp_value, rsp_ch.value);
          fail_count++;
        end
      end
      s = draw_gap();
      recv_stall   <= s;
      rsp_ch.ready <= (s == 0);
    end else if (recv_stall != 0) begin
      recv_stall   <= recv_stall - 1;
      rsp_ch.ready <= (recv_stall == 1);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Watchdog: counts cycles in which no transaction or register write happens.
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (req_ch.valid && req_ch.ready) ||
        (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_req(input xbr_pkg::op_t op, input logic [63:0] lo,
                         input logic [63:0] hi);
    pending_reqs.push_back('{op, lo, hi});
  endtask

  // Random requests: empty, small, huge and unconstrained ranges.
  task automatic add_random(input int unsigned count);
    logic [63:0] lo, hi;
    xbr_pkg::op_t op;
    for (int unsigned i = 0; i < count; i++) begin
      op = xbr_pkg::op_t'($urandom_range(0, 3));
      lo = rand64();
      case ($urandom_range(0, 9))
        0: hi = ($urandom_range(0, 1) == 0) ? lo : lo - 64'($urandom_range(1, 1000));
        1, 2, 3: hi = lo + 64'($urandom_range(1, 300));
        4: begin
          hi = lo + {1'b1, 31'd0, $urandom} + 64'($urandom_range(1, 9));
          hi[31:0] = lo[31:0] + 32'h8000_0000 + $urandom_range(1, 9);
        end
        default: hi = rand64();
      endcase
      add_req(op, lo, hi);
    end
  endtask

  // Wait until every queued request has been answered and the block has settled.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || expected_values.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] s);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= s;
    load_seed(s);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stimulus and end of run.
  initial begin
    fail_count  = 0;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    load_seed(64'd0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty ranges, extremes, ignored upper bits, heavy rejection.
    add_req(xbr_pkg::OP_U32, 64'd5, 64'd5);
    add_req(xbr_pkg::OP_U32, 64'hFFFF_FFFF, 64'd0);
    add_req(xbr_pkg::OP_S32, 64'h7FFF_FFFF, 64'h8000_0000);
    add_req(xbr_pkg::OP_S32, 64'hFFFF_FFFF, 64'd1);
    add_req(xbr_pkg::OP_U64, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    add_req(xbr_pkg::OP_S64, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    add_req(xbr_pkg::OP_S64, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
    add_req(xbr_pkg::OP_U64, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(xbr_pkg::OP_U32, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
    add_req(xbr_pkg::OP_S32, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_7FFF_FFFF);
    add_req(xbr_pkg::OP_S64, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    add_req(xbr_pkg::OP_U32, 64'd7, 64'd8);
    add_req(xbr_pkg::OP_U64, 64'd7, 64'd8);
    add_req(xbr_pkg::OP_U32, 64'd0, 64'd2);
    add_req(xbr_pkg::OP_U64, 64'd0, 64'h8000_0000_0000_0001);
    add_req(xbr_pkg::OP_U32, 64'd0, 64'h8000_0001);
    add_req(xbr_pkg::OP_S64, 64'hC000_0000_0000_0000, 64'h4000_0000_0000_0001);
    add_req(xbr_pkg::OP_S32, 64'hC000_0000, 64'h4000_0001);
    add_req(xbr_pkg::OP_U32, 64'hAAAA_AAAA_1234_5678, 64'h5555_5555_1234_5670);
    add_req(xbr_pkg::OP_U64, 64'd3, 64'd1000);
    add_random(380);
    wait_drained();

    // Further phases with extreme and random seeds.
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    add_random(380);
    wait_drained();
    write_seed(64'd0);
    add_random(380);
    wait_drained();
    write_seed(rand64());
    add_random(380);
    wait_drained();
    write_seed(rand64());
    add_random(380);
    wait_drained();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/xbr_pkg.sv
hdl/xbr_if.sv
hdl/xbr_front.sv
hdl/xbr_back.sv
hdl/xoshiro_bounded_random_top.sv
verif/tb_top.sv
